### sv/spd_pkg.sv
// spd_pkg: types, character codes and the hex digit decoder for the
// serial packet deframer. No dependencies; imported by the core.
package spd_pkg;

  // payload counter and limit register width
  localparam int unsigned LEN_W = 13;

  // hard ceiling on the frame payload, applied to the limit register
  localparam logic [LEN_W-1:0] MAX_FRAME = 13'd4096;

  // reset value of the limit register
  localparam logic [LEN_W-1:0] LIMIT_RESET = 13'd1024;

  // protocol characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$' frame start
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#' frame end
  localparam logic [7:0] CH_PLUS   = 8'h2b;  // '+' ack
  localparam logic [7:0] CH_MINUS  = 8'h2d;  // '-' nak

  // deframer phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_DATA = 4'b0010,
    PH_CK1  = 4'b0100,
    PH_CK2  = 4'b1000
  } phase_t;

  // kind of result item
  typedef enum logic [2:0] {
    K_PAYLOAD = 3'd0,
    K_NAK     = 3'd1,
    K_GOOD    = 3'd2,
    K_BAD     = 3'd3,
    K_END     = 3'd4
  } kind_t;

  // decoded hex digit: valid flag and value (zero when not a hex digit)
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d    = '{valid: 1'b0, value: 4'd0};
    diff = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      d    = '{valid: 1'b1, value: diff[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      d    = '{valid: 1'b1, value: diff[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      d    = '{valid: 1'b1, value: diff[3:0]};
    end
    return d;
  endfunction

endpackage

### sv/serial_packet_deframer_core.sv
// serial_packet_deframer_core: frame hunter, payload pass-through, mod-256
// checksum and hex checksum check with a registered result stage.
// Depends on spd_pkg.
//
// Usage
//   in channel  (in_valid/in_ready): one received byte rx_byte, or an end of
//     stream event when rx_end is high (rx_byte is then ignored).
//   out channel (out_valid/out_ready): at most one result item per input
//     item: a payload byte, a nak while hunting, frame good with its length,
//     checksum bad, or stream ended. '+'/'-' to send back are on tx_byte.
//   cfg channel (cfg_valid/cfg_ready): writes max_payload_len, the largest
//     payload of one frame (clamped to 4096). Write it only while idle.
// Timing
//   An item is decoded in the cycle it is accepted and its result is shown
//   from the next cycle. The only storage in the path is the phase/sum/count
//   state and the one output register, so one item is taken every cycle while
//   that register is empty or being taken. When the receiver stalls, the output
//   register holds and in_ready falls only while that register is full and not taken.
// Reset
//   rst (synchronous) returns to hunting with empty sums, drops any waiting
//   result and sets the limit to 1024.
module serial_packet_deframer_core
  import spd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             rx_end,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       result_kind,
  output logic [7:0]       payload_byte,
  output logic [7:0]       tx_byte,
  output logic [LEN_W-1:0] frame_length,
  output logic [7:0]       computed_sum,
  output logic [7:0]       received_sum,
  // configuration channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] max_payload_len
);

  // state
  logic [LEN_W-1:0] limit_reg;
  phase_t           phase;
  phase_t           phase_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic [LEN_W-1:0] byte_count;
  logic [LEN_W-1:0] byte_count_next;
  logic [3:0]       first_digit;
  logic [3:0]       first_digit_next;
  logic             first_digit_valid;
  logic             first_digit_valid_next;

  // result of the current item
  logic             res_emit;
  kind_t            res_kind;
  logic [7:0]       res_payload;
  logic [7:0]       res_tx;
  logic [LEN_W-1:0] res_len;
  logic [7:0]       res_csum;
  logic [7:0]       res_rsum;

  logic             in_fire;
  logic [LEN_W-1:0] limit_now;
  logic [LEN_W-1:0] count_inc;
  logic [7:0]       sum_inc;
  hex_digit_t       hex_in;
  logic [7:0]       rsum;

  // handshakes: output register frees the input side whenever it is taken
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // effective limit and per-byte arithmetic
  assign limit_now = (limit_reg > MAX_FRAME) ? MAX_FRAME : limit_reg;
  assign count_inc = byte_count + 1'b1;
  assign sum_inc   = running_sum + rx_byte;
  assign hex_in    = hex_decode(rx_byte);

  // received checksum from the two digits: zero if the first is not hex, the first alone if the second is not
  always_comb begin
    if (!first_digit_valid) begin
      rsum = 8'd0;
    end else if (hex_in.valid) begin
      rsum = {first_digit, hex_in.value};
    end else begin
      rsum = {4'd0, first_digit};
    end
  end

  // next state and result for one item
  always_comb begin
    phase_next             = phase;
    running_sum_next       = running_sum;
    byte_count_next        = byte_count;
    first_digit_next       = first_digit;
    first_digit_valid_next = first_digit_valid;
    res_emit    = 1'b0;
    res_kind    = K_PAYLOAD;
    res_payload = 8'd0;
    res_tx      = 8'd0;
    res_len     = '0;
    res_csum    = 8'd0;
    res_rsum    = 8'd0;
    if (rx_end) begin
      phase_next = PH_HUNT;
      res_emit   = 1'b1;
      res_kind   = K_END;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == CH_DOLLAR) begin
            running_sum_next       = 8'd0;
            byte_count_next        = '0;
            first_digit_next       = 4'd0;
            first_digit_valid_next = 1'b0;
            phase_next = (limit_now == '0) ? PH_CK1 : PH_DATA;
          end else if (rx_byte != CH_PLUS) begin
            res_emit = 1'b1;
            res_kind = K_NAK;
            res_tx   = CH_MINUS;
          end
        end
        PH_DATA: begin
          if (rx_byte == CH_HASH) begin
            phase_next = PH_CK1;
          end else begin
            running_sum_next = sum_inc;
            byte_count_next  = count_inc;
            if (count_inc >= limit_now) begin
              phase_next = PH_CK1;
            end
            res_emit    = 1'b1;
            res_kind    = K_PAYLOAD;
            res_payload = rx_byte;
          end
        end
        PH_CK1: begin
          first_digit_valid_next = hex_in.valid;
          first_digit_next       = hex_in.value;
          phase_next             = PH_CK2;
        end
        PH_CK2: begin
          phase_next = PH_HUNT;
          res_emit   = 1'b1;
          res_csum   = running_sum;
          res_rsum   = rsum;
          if (rsum == running_sum) begin
            res_kind = K_GOOD;
            res_tx   = CH_PLUS;
            res_len  = byte_count;
          end else begin
            res_kind = K_BAD;
            res_tx   = CH_MINUS;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_reg <= max_payload_len;
    end
  end

  // frame state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      running_sum       <= 8'd0;
      byte_count        <= '0;
      first_digit       <= 4'd0;
      first_digit_valid <= 1'b0;
    end else if (in_fire) begin
      phase             <= phase_next;
      running_sum       <= running_sum_next;
      byte_count        <= byte_count_next;
      first_digit       <= first_digit_next;
      first_digit_valid <= first_digit_valid_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire && res_emit) begin
      result_kind  <= res_kind;
      payload_byte <= res_payload;
      tx_byte      <= res_tx;
      frame_length <= res_len;
      computed_sum <= res_csum;
      received_sum <= res_rsum;
    end
  end

  // an end of stream item always answers with a stream-ended result and hunts
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && rx_end) |=>
      (out_valid && result_kind == K_END && phase == PH_HUNT))
    else $error("end of stream did not give a stream-ended result");

  // while collecting payload the count stays below the hard ceiling
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_count < MAX_FRAME))
    else $error("payload count reached the ceiling inside the data phase");

  // a good frame sends ack and its sums agree
  a_good_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == K_GOOD) |->
      (tx_byte == CH_PLUS && computed_sum == received_sum))
    else $error("good frame result is inconsistent");

  // a payload result carries no ack/nak, length or sums
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == K_PAYLOAD) |->
      (tx_byte == 8'd0 && frame_length == '0 && computed_sum == 8'd0))
    else $error("payload result carries stray fields");

endmodule

### sim/deframer_checker.sv
`timescale 1ns / 1ps
// deframer_checker: watches the input, result and limit channels of the
// serial packet deframer, predicts each result item and compares it.
// Depends on spd_pkg for widths, character codes, phases and result kinds.
module deframer_checker
  import spd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             rx_end,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       result_kind,
  input  logic [7:0]       payload_byte,
  input  logic [7:0]       tx_byte,
  input  logic [LEN_W-1:0] frame_length,
  input  logic [7:0]       computed_sum,
  input  logic [7:0]       received_sum,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LEN_W-1:0] max_payload_len,
  output int               mismatch_count,
  output int               pending_results
);

  // one predicted result item
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       payload;
    logic [7:0]       tx;
    logic [LEN_W-1:0] length;
    logic [7:0]       csum;
    logic [7:0]       rsum;
  } deframed_t;

  deframed_t        awaited_results[$];
  int               mismatch_total = 0;
  int               awaited_n = 0;

  // predictor state and its copy of the limit register
  phase_t           phase = PH_HUNT;
  logic [7:0]       sum_acc = 8'd0;
  logic [LEN_W-1:0] byte_cnt = '0;
  logic [3:0]       hi_nibble = 4'd0;
  logic             hi_nibble_ok = 1'b0;
  logic [LEN_W-1:0] limit_reg = LIMIT_RESET;

  assign mismatch_count  = mismatch_total;
  assign pending_results = awaited_n;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_total++;
  endtask

  // {is hex, value}; value is zero for anything but 0-9, a-f, A-F
  function automatic logic [4:0] hex_char(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // advance the deframer by one input item, queue the result it causes
  function automatic void deframe_byte(input logic [7:0] c, input logic stream_end);
    deframed_t        r;
    logic [4:0]       h;
    logic [7:0]       got;
    logic [LEN_W-1:0] lim;
    r   = '0;
    lim = (limit_reg > MAX_FRAME) ? MAX_FRAME : limit_reg;
    if (stream_end) begin
      phase  = PH_HUNT;
      r.kind = K_END;
      awaited_results.push_back(r);
    end else begin
      case (phase)
        PH_HUNT: begin
          if (c == CH_DOLLAR) begin
            sum_acc      = 8'd0;
            byte_cnt     = '0;
            hi_nibble    = 4'd0;
            hi_nibble_ok = 1'b0;
            phase        = (lim == 0) ? PH_CK1 : PH_DATA;
          end else if (c != CH_PLUS) begin
            r.kind = K_NAK;
            r.tx   = CH_MINUS;
            awaited_results.push_back(r);
          end
        end
        PH_DATA: begin
          if (c == CH_HASH) begin
            phase = PH_CK1;
          end else begin
            sum_acc  = sum_acc + c;
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt >= lim) phase = PH_CK1;
            r.kind    = K_PAYLOAD;
            r.payload = c;
            awaited_results.push_back(r);
          end
        end
        PH_CK1: begin
          h            = hex_char(c);
          hi_nibble_ok = h[4];
          hi_nibble    = h[3:0];
          phase        = PH_CK2;
        end
        default: begin
          // second digit: a bad first digit gives zero, a bad second one
          // leaves the first digit alone
          h = hex_char(c);
          if (!hi_nibble_ok) got = 8'd0;
          else if (h[4]) got = {hi_nibble, h[3:0]};
          else got = {4'd0, hi_nibble};
          phase  = PH_HUNT;
          r.csum = sum_acc;
          r.rsum = got;
          if (got == sum_acc) begin
            r.kind   = K_GOOD;
            r.tx     = CH_PLUS;
            r.length = byte_cnt;
          end else begin
            r.kind = K_BAD;
            r.tx   = CH_MINUS;
          end
          awaited_results.push_back(r);
        end
      endcase
    end
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin : watch
    deframed_t want;
    if (rst) begin
      awaited_results.delete();
      phase        = PH_HUNT;
      sum_acc      = 8'd0;
      byte_cnt     = '0;
      hi_nibble    = 4'd0;
      hi_nibble_ok = 1'b0;
      limit_reg    = LIMIT_RESET;
    end else begin
      // compare a taken result with the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result item with none awaited", 32'(result_kind), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (result_kind !== want.kind)
            report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
          if (payload_byte !== want.payload)
            report_mismatch("payload_byte", 32'(payload_byte), 32'(want.payload));
          if (tx_byte !== want.tx)
            report_mismatch("tx_byte", 32'(tx_byte), 32'(want.tx));
          if (frame_length !== want.length)
            report_mismatch("frame_length", 32'(frame_length), 32'(want.length));
          if (computed_sum !== want.csum)
            report_mismatch("computed_sum", 32'(computed_sum), 32'(want.csum));
          if (received_sum !== want.rsum)
            report_mismatch("received_sum", 32'(received_sum), 32'(want.rsum));
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = max_payload_len;
      if (in_valid && in_ready) deframe_byte(rx_byte, rx_end);
    end
    awaited_n <= awaited_results.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives bytes, end events and limit writes into the serial
// packet deframer with random idling; deframer_checker does the comparing.
// Depends on spd_pkg, serial_packet_deframer_core and deframer_checker.
module testbench
  import spd_pkg::*;
();

  localparam int CYCLE_LIMIT = 500000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'd0;
  logic             rx_end = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  logic [2:0]       result_kind;
  logic [7:0]       payload_byte;
  logic [7:0]       tx_byte;
  logic [LEN_W-1:0] frame_length;
  logic [7:0]       computed_sum;
  logic [7:0]       received_sum;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] max_payload_len = '0;
  int               mismatch_count;
  int               pending_results;

  int gap_odds = 0;     // chance in 16 of an idle burst, per side
  int items_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;

  serial_packet_deframer_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .rx_end(rx_end),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .payload_byte(payload_byte), .tx_byte(tx_byte), .frame_length(frame_length),
    .computed_sum(computed_sum), .received_sum(received_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_payload_len(max_payload_len)
  );

  deframer_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .rx_end(rx_end),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .payload_byte(payload_byte), .tx_byte(tx_byte), .frame_length(frame_length),
    .computed_sum(computed_sum), .received_sum(received_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_payload_len(max_payload_len),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls in random bursts, each begun with a chance of gap_odds in 16
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one item on the input channel, with an optional idle burst first
  task automatic send_item(input logic [7:0] b, input logic stream_end);
    if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    rx_end   <= stream_end;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop sending and wait until every awaited result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_valid       <= 1'b1;
    max_payload_len <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ascii for a nibble, letters in random case
  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    logic [7:0] base;
    base = ($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41;
    if (n < 4'd10) return 8'h30 + n;
    return base + n - 8'd10;
  endfunction

  // characters just outside the hex ranges, whitespace, signs, nul
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 11))
      0:       return 8'h20;   // space
      1:       return 8'h09;   // tab
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      4:       return CH_HASH;
      5:       return 8'h00;
      6:       return 8'h67;   // 'g'
      7:       return 8'h47;   // 'G'
      8:       return 8'h2f;   // '/'
      9:       return 8'h3a;   // ':'
      10:      return 8'h40;   // '@'
      default: return 8'h60;   // '`'
    endcase
  endfunction

  // well-formed frame with random payload and mostly correct checksum
  task automatic send_frame(input int lim, input int len);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] d1;
    logic [7:0] d2;
    int         i;
    sum = 8'd0;
    send_item(CH_DOLLAR, 1'b0);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_HASH) b = CH_DOLLAR;  // keep the frame open
      sum = sum + b;
      send_item(b, 1'b0);
    end
    // at the limit the checksum follows directly
    if (len < lim) send_item(CH_HASH, 1'b0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        d1 = hex_ascii(sum[7:4]);
        d2 = hex_ascii(sum[3:0]);
      end
      6, 7: begin
        d1 = hex_ascii(4'($urandom_range(0, 15)));
        d2 = hex_ascii(4'($urandom_range(0, 15)));
      end
      8: begin
        d1 = hex_ascii(sum[7:4]);
        d2 = non_hex_char();
      end
      default: begin
        d1 = non_hex_char();
        d2 = ($urandom_range(0, 1) == 1) ? hex_ascii(4'($urandom_range(0, 15)))
                                         : non_hex_char();
      end
    endcase
    send_item(d1, 1'b0);
    send_item(d2, 1'b0);
  endtask

  // mix of frames, stray bytes, end events and cut-off frames
  task automatic run_traffic(input int count, input int lim);
    int stop_at;
    int len;
    int pick;
    int i;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (lim <= 16)
          len = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(0, lim);
        else
          len = $urandom_range(0, 12);
        send_frame(lim, len);
      end else if (pick < 80) begin
        send_item(($urandom_range(0, 3) == 0) ? CH_PLUS : 8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 88) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 98) begin
        send_item(CH_DOLLAR, 1'b0);
        for (i = $urandom_range(0, 3); i > 0; i--)
          send_item(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1) == 1) send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        drain();
      end
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [LEN_W-1:0] limits[8];
    int               lim_eff;
    int               k;
    limits = '{13'd0, 13'd1, 13'd3, 13'd4096, 13'd8191, 13'd2, 13'd9, 13'd1024};
    limits[6] = 13'($urandom_range(4, 40));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, at the reset limit
    send_item(CH_PLUS, 1'b0);          // ignored while hunting
    send_item(8'h00, 1'b0);            // stray byte, nak
    send_item(CH_DOLLAR, 1'b0);        // "Ab" with correct sum a3
    send_item(8'h41, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(CH_HASH, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(CH_DOLLAR, 1'b0);        // ff payload, checksum "Fe" is wrong
    send_item(8'hff, 1'b0);
    send_item(CH_HASH, 1'b0);
    send_item(8'h46, 1'b0);
    send_item(8'h65, 1'b0);
    send_item(CH_DOLLAR, 1'b0);        // empty frame, space as first digit
    send_item(CH_HASH, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h30, 1'b0);
    send_item(CH_DOLLAR, 1'b0);        // second digit not hex, first alone
    send_item(8'h05, 1'b0);
    send_item(CH_HASH, 1'b0);
    send_item(8'h35, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(CH_DOLLAR, 1'b0);        // stream ends inside a frame
    send_item(8'h71, 1'b0);
    send_item(8'ha5, 1'b1);
    send_item(8'h5a, 1'b1);            // stream ends while hunting
    drain();

    // random phases over several limits, the last one without idling
    for (k = 0; k < 8; k++) begin
      gap_odds = (k == 7) ? 0 : $urandom_range(0, 4);
      write_limit(limits[k]);
      lim_eff = (limits[k] > MAX_FRAME) ? MAX_FRAME : limits[k];
      run_traffic(250, lim_eff);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
sv/spd_pkg.sv
sv/serial_packet_deframer_core.sv
sim/deframer_checker.sv
sim/testbench.sv
